// ----- hw/rtl/itra_pkg.sv -----
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and helpers of the radix integer-to-text converter.
// ----------------------------------------------------------------------------
package itra_pkg;

    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int REQ_W      = 6;
    localparam int OUT_DATA_W = 16;   // char + length, padded to whole bytes

    localparam logic [RADIX_W-1:0] DEFAULT_RADIX = 6'd10;
    localparam logic [RADIX_W-1:0] MIN_RADIX     = 6'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX     = 6'd36;

    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'h37;  // 'A' - 10
    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;  // '-'

    localparam logic [REQ_W-1:0] REQ_MAX = 6'd63;

    typedef struct packed {
        logic busy;   // back end is working on an item
        logic pop;    // back end takes the head of the queue this cycle
    } t_back_status;

    // digit value (below 36) to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {2'b00, d};
        if (d < 6'd10) begin
            return CHAR_ZERO + ext;
        end else begin
            return CHAR_ALPHA_OFS + ext;
        end
    endfunction

endpackage

// ----- hw/rtl/int_to_radix_ascii_core.sv -----
// ----------------------------------------------------------------------------
// int_to_radix_ascii_core
// Signed integer to ASCII text in a configurable radix, one character per
// output transfer.
// ----------------------------------------------------------------------------
// Each input transfer carries one signed VALUE_WIDTH-bit integer. The block
// answers with one output transfer per character, most significant first: a
// leading '-' for negative values, then digits 0-9 and A-Z; zero gives "0".
// tlast marks the final character, and every character of a conversion
// carries the required length (sign + digits + terminator, saturating at 63).
// The radix register (2..36, anything else means 10, reset 10) is written
// through the cfg channel; the user must do so only while the block is idle,
// which the block itself does not enforce. The divider retires 8 quotient
// bits per cycle; each digit goes into the digit RAM, and once the value is
// fully divided the output reads the digits back through the RAM read port,
// after a sign character for negative values. A two-entry queue lets the
// next values be accepted while a conversion runs.
// ----------------------------------------------------------------------------
module int_to_radix_ascii_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration: radix
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [itra_pkg::RADIX_W-1:0]         i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // [W-1:0] value
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [itra_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [7:0] out_char,
                                                                 // [13:8] text_len
    output logic                                 m_axis_tlast    // last
);

    localparam int ITEM_W = VALUE_WIDTH + itra_pkg::RADIX_W + 1;

    logic                          push;
    logic [ITEM_W-1:0]             push_item;
    logic                          queue_full;
    logic                          queue_valid;
    logic [ITEM_W-1:0]             queue_item;
    itra_pkg::t_back_status        back_status;
    logic [itra_pkg::CHAR_W-1:0]   out_char;
    logic [itra_pkg::REQ_W-1:0]    out_req;

    assign o_cfg_ready = 1'b1;

    itra_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_value      (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_queue_full (queue_full),
        .o_in_ready   (s_axis_tready),
        .o_push       (push),
        .o_item       (push_item)
    );

    itra_fifo #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (back_status.pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_item)
    );

    itra_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_status     (back_status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_char       (out_char),
        .o_last       (m_axis_tlast),
        .o_req        (out_req)
    );

    assign m_axis_tdata = {2'b00, out_req, out_char};

`ifndef SYNTH
    // a sign character is never the end of a conversion
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (out_char == itra_pkg::CHAR_MINUS) |-> !m_axis_tlast)
        else $error("sign character flagged as last");

    // shortest text is one digit plus terminator
    a_req_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_req >= itra_pkg::REQ_W'(2)))
        else $error("required length below two");

    // taking an item from the queue starts a conversion
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.pop |=> back_status.busy)
        else $error("queue popped but back end idle");
`endif

endmodule

// ----- hw/rtl/itra_ram.sv -----
// ----------------------------------------------------------------------------
// itra_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/itra_front.sv -----
// ----------------------------------------------------------------------------
// itra_front
// Input side: holds the radix register, takes values, forms sign, magnitude
// and effective base and pushes them into the work queue.
// ----------------------------------------------------------------------------
module itra_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [itra_pkg::RADIX_W-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    input  logic [VALUE_WIDTH-1:0]           i_value,
    input  logic                             i_queue_full,
    output logic                             o_in_ready,
    output logic                             o_push,
    output logic [VALUE_WIDTH+itra_pkg::RADIX_W:0] o_item  // {neg, base, mag}
);

    logic [itra_pkg::RADIX_W-1:0] r_radix;
    logic [itra_pkg::RADIX_W-1:0] base;
    logic                         negative;
    logic [VALUE_WIDTH-1:0]       magnitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= itra_pkg::DEFAULT_RADIX;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    assign base = (r_radix >= itra_pkg::MIN_RADIX && r_radix <= itra_pkg::MAX_RADIX) ?
                  r_radix : itra_pkg::DEFAULT_RADIX;

    // most negative value maps to 2^(W-1), still fits as unsigned
    assign negative  = i_value[VALUE_WIDTH-1];
    assign magnitude = negative ? (~i_value + VALUE_WIDTH'(1)) : i_value;

    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;
    assign o_item     = {negative, base, magnitude};

endmodule

// ----- hw/rtl/itra_fifo.sv -----
// ----------------------------------------------------------------------------
// itra_fifo
// Two-entry queue between front and back ends.
// ----------------------------------------------------------------------------
module itra_fifo #(
    parameter int WIDTH = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

endmodule

// ----- hw/rtl/itra_back.sv -----
// ----------------------------------------------------------------------------
// itra_back
// Conversion engine: iterative divide-by-radix producing one digit per pass,
// digit store in RAM, then emits sign and digits most significant first.
// ----------------------------------------------------------------------------
module itra_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_item_valid,
    input  logic [VALUE_WIDTH+itra_pkg::RADIX_W:0] i_item,
    output itra_pkg::t_back_status                 o_status,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [itra_pkg::CHAR_W-1:0]            o_char,
    output logic                                   o_last,
    output logic [itra_pkg::REQ_W-1:0]             o_req
);

    localparam int DIV_BITS = 8;                                   // quotient bits per cycle
    localparam int NSTEP    = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DW       = NSTEP * DIV_BITS;
    localparam int SW       = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int DEPTH    = VALUE_WIDTH + 1;
    localparam int AW       = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int LEN_W    = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;
    localparam int RW       = itra_pkg::RADIX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_OUT
    } t_state;

    t_state                      r_state;
    logic [DW-1:0]               r_div;
    logic [RW-1:0]               r_rem;
    logic [RW-1:0]               r_base;
    logic [SW-1:0]               r_step;
    logic                        r_neg;
    logic [CNT_W-1:0]            r_cnt;
    logic [AW-1:0]               r_idx;
    logic                        r_ovalid;
    logic [itra_pkg::CHAR_W-1:0] r_ochar;
    logic                        r_olast;
    logic [itra_pkg::REQ_W-1:0]  r_oreq;
    logic [itra_pkg::REQ_W-1:0]  r_req;

    logic [DW-1:0]               n_quo;
    logic [RW-1:0]               n_rem;
    logic [RW:0]                 trial;
    logic [CNT_W-1:0]            n_cnt;
    logic [LEN_W-1:0]            n_len;
    logic [itra_pkg::REQ_W-1:0]  n_req;
    logic                        digit_done;
    logic                        out_free;
    logic                        emit;
    logic                        pop;
    logic [itra_pkg::CHAR_W-1:0] ram_rdata;

    // restoring division, DIV_BITS quotient bits per cycle on a 6-bit remainder
    always_comb begin
        n_rem = r_rem;
        n_quo = r_div;
        trial = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem, n_quo[DW-1]};
            n_quo = {n_quo[DW-2:0], 1'b0};
            if (trial >= {1'b0, r_base}) begin
                n_rem    = RW'(trial - {1'b0, r_base});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = trial[RW-1:0];
            end
        end
    end

    assign digit_done = (r_state == ST_DIV) && (r_step == SW'(NSTEP - 1));
    assign n_cnt      = r_cnt + CNT_W'(1);
    assign n_len      = LEN_W'(n_cnt) + (r_neg ? LEN_W'(2) : LEN_W'(1));
    assign n_req      = (n_len > LEN_W'(itra_pkg::REQ_MAX)) ? itra_pkg::REQ_MAX :
                        n_len[itra_pkg::REQ_W-1:0];
    assign out_free   = !r_ovalid || i_out_ready;
    assign emit       = out_free && ((r_state == ST_SIGN) || (r_state == ST_OUT));
    assign pop        = (r_state == ST_IDLE) && i_item_valid;

    itra_ram #(
        .WIDTH (itra_pkg::CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (digit_done),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (itra_pkg::digit_char(n_rem)),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_div   <= DW'(i_item[VALUE_WIDTH-1:0]);
                        r_base  <= i_item[VALUE_WIDTH+RW-1:VALUE_WIDTH];
                        r_neg   <= i_item[VALUE_WIDTH+RW];
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (digit_done) begin
                        r_cnt  <= n_cnt;
                        r_div  <= n_quo;
                        r_rem  <= '0;
                        r_step <= '0;
                        if (n_quo == '0) begin
                            r_req   <= n_req;
                            r_idx   <= r_cnt[AW-1:0];
                            r_state <= r_neg ? ST_SIGN : ST_RD;
                        end
                    end else begin
                        r_div  <= n_quo;
                        r_rem  <= n_rem;
                        r_step <= r_step + SW'(1);
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        r_ochar  <= itra_pkg::CHAR_MINUS;
                        r_olast  <= 1'b0;
                        r_oreq   <= r_req;
                        r_state  <= ST_RD;
                    end
                end
                ST_RD: begin
                    // store read at r_idx lands next cycle
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ochar  <= ram_rdata;
                        r_olast  <= (r_idx == '0);
                        r_oreq   <= r_req;
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx - AW'(1);
                            r_state <= ST_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_status.busy = (r_state != ST_IDLE);
    assign o_status.pop  = pop;
    assign o_out_valid   = r_ovalid;
    assign o_char        = r_ochar;
    assign o_last        = r_olast;
    assign o_req         = r_oreq;

endmodule

// ----- sim/tb_int_to_radix_ascii_core.sv -----
// ----------------------------------------------------------------------------
// tb_int_to_radix_ascii_core
// Self-checking bench for the radix integer-to-text converter.
// ----------------------------------------------------------------------------
// Values are streamed in bursts with random gaps, and the output side stalls
// on changing patterns. Each accepted value is expanded into its expected
// characters, and every output transfer is checked against the oldest one.
// The radix is swept over in-range, edge and out-of-range settings, and each
// new setting is written only once the block has drained.
// ----------------------------------------------------------------------------
module tb_int_to_radix_ascii_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [itra_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic [itra_pkg::REQ_W-1:0]  req;
    } t_text_char;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_BURSTY
    } t_sink_mode;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic [itra_pkg::RADIX_W-1:0]     i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [31:0]                      s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [itra_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tlast;

    logic [31:0]                  pending_values[$];
    t_text_char                   expected_chars[$];
    logic [itra_pkg::RADIX_W-1:0] radix_setting = itra_pkg::DEFAULT_RADIX;
    int                           mismatch_count = 0;
    int                           burst_left = 1;
    int                           gap_left = 0;
    t_sink_mode                   sink_mode = SINK_OPEN;
    int                           mode_left = 0;
    int                           stall_left = 0;

    int_to_radix_ascii_core #(
        .VALUE_WIDTH(32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // effective base: anything outside 2..36 falls back to decimal
    function automatic logic [31:0] base_of(input logic [itra_pkg::RADIX_W-1:0] r);
        return (r >= 6'd2 && r <= 6'd36) ? {26'd0, r} : 32'd10;
    endfunction

    // expand one value into the characters the block should emit
    function automatic void predict_text(input logic [31:0] value);
        string       glyphs;
        logic [7:0]  digits[33];
        logic [31:0] mag;
        logic [31:0] base;
        logic        neg;
        logic [5:0]  req;
        int          n;
        glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
        neg  = value[31];
        mag  = neg ? -value : value;   // most negative stays 2^31 as unsigned
        base = base_of(radix_setting);
        n    = 0;
        if (mag == 0) begin
            digits[0] = glyphs[0];
            n = 1;
        end
        while (mag != 0) begin
            digits[n] = glyphs[mag % base];
            n++;
            mag = mag / base;
        end
        req = 6'(n + (neg ? 2 : 1));
        if (neg) begin
            expected_chars.push_back('{ch: itra_pkg::CHAR_MINUS, last: 1'b0, req: req});
        end
        for (int i = n - 1; i >= 0; i--) begin
            expected_chars.push_back('{ch: digits[i], last: (i == 0), req: req});
        end
    endfunction

    // random value biased toward digit-count boundaries and extremes
    function automatic logic [31:0] pick_value(input logic [itra_pkg::RADIX_W-1:0] r);
        logic [31:0] v;
        logic [31:0] b;
        int          k;
        b = base_of(r);
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 40);
            3: v = -$urandom_range(0, 40);
            4: begin
                v = 1;
                k = $urandom_range(1, 31);
                repeat (k) begin
                    if (v < 32'h8000_0000 / b) v = v * b;
                end
                v = v + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    default: v = 32'h7FFF_FFFE;
                endcase
            end
        endcase
        return v;
    endfunction

    // input driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_text(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_values.size() != 0) begin
                    s_axis_tdata  <= pending_values.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected transfer: expected none, got char %h last %b len %0d",
                             $time, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[13:8]);
                end else begin
                    t_text_char want;
                    want = expected_chars.pop_front();
                    if (m_axis_tdata[7:0] !== want.ch) begin
                        mismatch_count++;
                        $display("%0t out_char: expected %h, got %h",
                                 $time, want.ch, m_axis_tdata[7:0]);
                    end
                    if (m_axis_tlast !== want.last) begin
                        mismatch_count++;
                        $display("%0t last: expected %b, got %b", $time, want.last, m_axis_tlast);
                    end
                    if (m_axis_tdata[13:8] !== want.req) begin
                        mismatch_count++;
                        $display("%0t text_len: expected %0d, got %0d",
                                 $time, want.req, m_axis_tdata[13:8]);
                    end
                end
            end
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end else begin
                mode_left--;
            end
            case (sink_mode)
                SINK_OPEN:   m_axis_tready <= 1'b1;
                SINK_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_left == 0) begin
                        m_axis_tready <= 1'b1;
                        stall_left = $urandom_range(0, 20);
                    end else begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end
                end
            endcase
        end
    end

    // wait until the block has emitted everything predicted so far
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_values.size() != 0 || s_axis_tvalid || expected_chars.size() != 0);
    endtask

    task automatic write_radix(input logic [itra_pkg::RADIX_W-1:0] r);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= r;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        radix_setting = r;
    endtask

    initial begin
        logic [itra_pkg::RADIX_W-1:0] radix_plan[15];
        radix_plan = '{6'd2, 6'd36, 6'd0, 6'd16, 6'd1, 6'd8, 6'd37, 6'd3,
                       6'd63, 6'd10, 6'd7, 6'd35, 6'd20, 6'd4, 6'd2};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset radix: zero, signs, extremes, decimal digit-count edges
        pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'd9, 32'd10, 32'd99, -32'd100, 32'hAAAA_AAAA, 32'h5555_5555};
        repeat (22) pending_values.push_back(pick_value(radix_setting));
        wait_drained();

        for (int p = 0; p < 17; p++) begin
            logic [itra_pkg::RADIX_W-1:0] r;
            r = (p < 15) ? radix_plan[p] : 6'($urandom_range(0, 63));
            write_radix(r);
            if (r == 6'd2) begin
                // most negative in binary gives the longest text
                pending_values.push_back(32'h8000_0000);
                pending_values.push_back(32'h7FFF_FFFF);
                pending_values.push_back(32'hFFFF_FFFF);
                pending_values.push_back(32'd1);
            end else if (r == 6'd36) begin
                pending_values.push_back(32'd35);
                pending_values.push_back(32'd36);
                pending_values.push_back(-32'd35);
                pending_values.push_back(32'h8000_0000);
            end else if (r == 6'd63) begin
                pending_values.push_back(32'd10);
                pending_values.push_back(32'hFFFF_FFFF);
            end
            repeat (18) pending_values.push_back(pick_value(r));
            wait_drained();
        end

        // trailing window: any extra output transfer shows up as unexpected
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_int_to_radix_ascii_core: clean");
        end else begin
            $display("tb_int_to_radix_ascii_core: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_int_to_radix_ascii_core: errors");
        $finish;
    end

endmodule
